// ----- hdl/utf8tlc_pkg.sv -----
// Package with the shared types and constants of the UTF-8 text length checker.
`timescale 1ns / 1ps

package utf8tlc_pkg;

  // Verdict codes carried in the result word.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_ILLEGAL  = 2'd2,
    STATUS_TOO_LONG = 2'd3
  } status_t;

  localparam int unsigned TEXT_W  = 8;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned PEND_W  = 2;
  localparam int unsigned TDATA_W = 8;

  localparam logic [LIMIT_W-1:0] MAX_BYTES_RESET = 16'd255;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 17'h1FFFF;

  // Byte class boundaries.
  localparam logic [TEXT_W-1:0] CONT_LO  = 8'h80;
  localparam logic [TEXT_W-1:0] LEAD2_LO = 8'hC0;
  localparam logic [TEXT_W-1:0] LEAD3_LO = 8'hE0;
  localparam logic [TEXT_W-1:0] LEAD4_LO = 8'hF0;
  localparam logic [TEXT_W-1:0] LEAD_END = 8'hF5;

endpackage

// ----- hdl/utf8tlc_obuf.sv -----
// Two-entry output buffer that holds verdicts while the result side stalls.
`timescale 1ns / 1ps

module utf8tlc_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  utf8tlc_pkg::status_t push_status,
  output logic                push_ready,
  output logic                out_valid,
  output utf8tlc_pkg::status_t out_status,
  input  logic                out_ready
);
  import utf8tlc_pkg::*;

  logic    head_valid_r, head_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  status_t head_r, head_nxt;
  status_t skid_r, skid_nxt;
  logic    pop;

  assign pop        = head_valid_r && out_ready;
  assign push_ready = !skid_valid_r;
  assign out_valid  = head_valid_r;
  assign out_status = head_r;

  // Next state of the head and skid entries.
  always_comb begin
    head_valid_nxt = head_valid_r;
    skid_valid_nxt = skid_valid_r;
    head_nxt       = head_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      // No push can arrive while the skid entry is full.
      if (pop) begin
        head_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!head_valid_r || pop) begin
      head_valid_nxt = push;
      head_nxt       = push_status;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ----- hdl/utf8_text_length_checker.sv -----
// Top level of the UTF-8 text length checker.
// The checker takes one byte word per cycle and gives one verdict word per
// zero-terminated string: ok, empty, illegal byte or too long. Each byte
// updates the per-string state (saturating byte count, expected continuation
// bytes, discard flag) in the cycle it is accepted, and a verdict is registered
// into the output buffer. The two-entry buffer lets input continue
// while one verdict waits; input stalls only when two verdicts are held. The
// limit max_bytes (reset 255) is written through cfg_wr_en/cfg_wr_data and
// should only be changed while no string is in progress.
`timescale 1ns / 1ps

module utf8_text_length_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input word: [7:0] text_byte
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [utf8tlc_pkg::TDATA_W-1:0]   in_tdata,
  // Result word: [1:0] status, [7:2] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [utf8tlc_pkg::TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [utf8tlc_pkg::LIMIT_W-1:0]   cfg_wr_data
);
  import utf8tlc_pkg::*;

  logic [LIMIT_W-1:0] max_bytes_r;
  logic [COUNT_W-1:0] count_r, count_nxt, count_inc;
  logic [PEND_W-1:0]  pend_r, pend_nxt;
  logic               discard_r, discard_nxt;
  logic               accept;
  logic               res_valid;
  status_t            res_status;
  status_t            out_status;
  logic [TEXT_W-1:0]  b;
  logic               is_cont;

  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign is_cont   = (b >= CONT_LO) && (b < LEAD2_LO);
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;

  // Per-byte state update and verdict.
  always_comb begin
    count_nxt   = count_r;
    pend_nxt    = pend_r;
    discard_nxt = discard_r;
    res_valid   = 1'b0;
    res_status  = STATUS_OK;
    if (accept) begin
      if (discard_r) begin
        if (b == '0) begin
          count_nxt   = '0;
          pend_nxt    = '0;
          discard_nxt = 1'b0;
        end
      end else if (pend_r != '0) begin
        if (!is_cont) begin
          res_valid  = 1'b1;
          res_status = STATUS_ILLEGAL;
          if (b == '0) begin
            count_nxt = '0;
            pend_nxt  = '0;
          end else begin
            discard_nxt = 1'b1;
          end
        end else begin
          count_nxt = count_inc;
          pend_nxt  = pend_r - 1'b1;
          if (pend_r == PEND_W'(1) && count_inc > {1'b0, max_bytes_r}) begin
            res_valid   = 1'b1;
            res_status  = STATUS_TOO_LONG;
            discard_nxt = 1'b1;
          end
        end
      end else if (b == '0) begin
        // End of string at a character boundary.
        res_valid  = 1'b1;
        res_status = (count_r == '0) ? STATUS_EMPTY : STATUS_OK;
        count_nxt  = '0;
        pend_nxt   = '0;
      end else if (is_cont || b >= LEAD_END) begin
        res_valid   = 1'b1;
        res_status  = STATUS_ILLEGAL;
        discard_nxt = 1'b1;
      end else begin
        count_nxt = count_inc;
        if (b < CONT_LO) begin
          if (count_inc > {1'b0, max_bytes_r}) begin
            res_valid   = 1'b1;
            res_status  = STATUS_TOO_LONG;
            discard_nxt = 1'b1;
          end
        end else if (b < LEAD3_LO) begin
          pend_nxt = PEND_W'(1);
        end else if (b < LEAD4_LO) begin
          pend_nxt = PEND_W'(2);
        end else begin
          pend_nxt = PEND_W'(3);
        end
      end
    end
  end

  // String state and limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= '0;
      discard_r   <= 1'b0;
      max_bytes_r <= MAX_BYTES_RESET;
    end else begin
      count_r   <= count_nxt;
      pend_r    <= pend_nxt;
      discard_r <= discard_nxt;
      if (cfg_wr_en) begin
        max_bytes_r <= cfg_wr_data;
      end
    end
  end

  // Verdict buffer toward the result side.
  utf8tlc_obuf u_obuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (res_valid),
    .push_status (res_status),
    .push_ready  (in_tready),
    .out_valid   (out_tvalid),
    .out_status  (out_status),
    .out_ready   (out_tready)
  );

  assign out_tdata = {{(TDATA_W-2){1'b0}}, out_status};

endmodule

// ----- hdl/utf8tlc_checker.sv -----
// Port-level assertions for the UTF-8 text length checker and their bind.
`timescale 1ns / 1ps

module utf8tlc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [utf8tlc_pkg::TDATA_W-1:0] out_tdata
);

  // A held verdict must not change until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("verdict changed while stalled");

  // A new verdict appears only after a byte word was accepted.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("verdict without an accepted byte");

  // Input only stalls while verdicts are held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no verdict waiting");

  // The result word carries only the two status bits.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:2] == 6'd0)
    else $error("nonzero padding in result word");

endmodule

bind utf8_text_length_checker utf8tlc_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- sim/utf8_verdict_checker.sv -----
// Verdict predictor and scoreboard for the UTF-8 text length checker.
`timescale 1ns / 1ps

module utf8_verdict_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [utf8tlc_pkg::TDATA_W-1:0]   in_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [utf8tlc_pkg::TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [utf8tlc_pkg::LIMIT_W-1:0]   cfg_wr_data,
  output int unsigned                       fail_count,
  output int unsigned                       verdicts_waiting,
  output int unsigned                       live_bytes,
  output int unsigned                       verdicts_checked
);
  import utf8tlc_pkg::*;

  // Predicted per-string state and the current length limit.
  logic [LIMIT_W-1:0] limit_q;
  logic [COUNT_W-1:0] count_q;
  logic [PEND_W-1:0]  pend_q;
  logic               skip_q;

  // Verdicts predicted but not yet seen on the result side, oldest first.
  status_t verdict_q[$];

  task automatic clear_text();
    count_q = '0;
    pend_q  = '0;
    skip_q  = 1'b0;
  endtask

  task automatic bump_count();
    if (count_q != COUNT_MAX) begin
      count_q = count_q + 1'b1;
    end
  endtask

  // Advance the predicted state by one text byte and tell whether it ends in a verdict.
  task automatic judge_byte(input logic [TEXT_W-1:0] b, output bit has_verdict,
                            output status_t verdict);
    has_verdict = 1'b0;
    verdict     = STATUS_OK;
    if (skip_q) begin
      // Rest of a string that already has its verdict; the zero ends it quietly.
      if (b == '0) begin
        clear_text();
      end
    end else if (pend_q != '0) begin
      // Inside a multi-byte character: only continuation bytes are legal.
      if (b < CONT_LO || b >= LEAD2_LO) begin
        has_verdict = 1'b1;
        verdict     = STATUS_ILLEGAL;
        if (b == '0) begin
          clear_text();
        end else begin
          skip_q = 1'b1;
        end
      end else begin
        bump_count();
        pend_q = pend_q - 2'd1;
        if (pend_q == '0 && count_q > limit_q) begin
          has_verdict = 1'b1;
          verdict     = STATUS_TOO_LONG;
          skip_q      = 1'b1;
        end
      end
    end else if (b == '0) begin
      // Terminator at a character boundary.
      has_verdict = 1'b1;
      verdict     = (count_q == '0) ? STATUS_EMPTY : STATUS_OK;
      clear_text();
    end else if (b >= CONT_LO && (b < LEAD2_LO || b >= LEAD_END)) begin
      has_verdict = 1'b1;
      verdict     = STATUS_ILLEGAL;
      skip_q      = 1'b1;
    end else begin
      bump_count();
      if (b < CONT_LO) begin
        if (count_q > limit_q) begin
          has_verdict = 1'b1;
          verdict     = STATUS_TOO_LONG;
          skip_q      = 1'b1;
        end
      end else if (b < LEAD3_LO) begin
        pend_q = 2'd1;
      end else if (b < LEAD4_LO) begin
        pend_q = 2'd2;
      end else begin
        pend_q = 2'd3;
      end
    end
  endtask

  // Watch all three ports at each rising edge; results are compared before new bytes
  // are judged so a verdict can never match its own byte in the same cycle.
  always @(posedge clk) begin
    bit      has_verdict;
    status_t verdict;
    status_t wanted;
    if (!rst_n) begin
      limit_q = MAX_BYTES_RESET;
      clear_text();
      verdict_q.delete();
      fail_count       = 0;
      live_bytes       = 0;
      verdicts_checked = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: verdict word 0x%02h arrived with none expected", $time, out_tdata);
          end
        end else begin
          wanted = verdict_q.pop_front();
          verdicts_checked++;
          if (out_tdata[1:0] != wanted || out_tdata[TDATA_W-1:2] != '0) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: verdict mismatch: expected status %0d (word 0x%02h), got 0x%02h",
                       $time, wanted, {6'b0, wanted}, out_tdata);
            end
          end
        end
      end
      if (cfg_wr_en) begin
        limit_q = cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        if (!skip_q) begin
          live_bytes++;
        end
        judge_byte(in_tdata[TEXT_W-1:0], has_verdict, verdict);
        if (has_verdict) begin
          verdict_q.push_back(verdict);
        end
      end
    end
    verdicts_waiting = verdict_q.size();
  end

endmodule

// ----- sim/tb.sv -----
// Top of the UTF-8 text length checker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import utf8tlc_pkg::*;

  localparam int unsigned LONG_HOLD    = 250;
  localparam int unsigned PHASE_BYTES  = 100;
  localparam int unsigned FIRST_BYTES  = 300;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_tvalid   = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata    = '0;
  logic                 out_tvalid;
  logic                 out_tready  = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;
  logic                 cfg_wr_en   = 1'b0;
  logic [LIMIT_W-1:0]   cfg_wr_data = '0;

  int unsigned fail_count;
  int unsigned verdicts_waiting;
  int unsigned live_bytes;
  int unsigned verdicts_checked;

  // Shared pacing controls: steady turns idling off on both sides for a while,
  // and hold_request asks the result side for one long hold-off.
  bit          steady       = 1'b0;
  bit          hold_request = 1'b0;
  logic [15:0] limit_now    = MAX_BYTES_RESET;
  int unsigned bytes_sent   = 0;
  int unsigned strings_sent = 0;
  int unsigned settings_used = 1;

  logic [7:0] opening [0:27];

  always #4 clk = ~clk;

  utf8_text_length_checker dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  utf8_verdict_checker verdict_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .fail_count       (fail_count),
    .verdicts_waiting (verdicts_waiting),
    .live_bytes       (live_bytes),
    .verdicts_checked (verdicts_checked)
  );

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offer one byte word, after an optional gap, and wait for its handshake.
  // Called and returns at a falling edge.
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
    if (b == 8'h00) strings_sent++;
  endtask

  // Stop offering and wait until every predicted verdict has been delivered.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (verdicts_waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_limit(input logic [15:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    limit_now    = v;
    settings_used++;
  endtask

  // One random string: mostly well-formed UTF-8 of a length near or below the limit,
  // some with one byte replaced by noise, and some pure noise.
  task automatic send_random_string();
    int unsigned lim, kind, target, sent, break_at, n, k;
    bit          broken;
    logic [7:0]  char_bytes [0:3];
    lim = limit_now;
    if ($urandom_range(0, 9) == 0) steady = ~steady;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      n = $urandom_range(1, 10);
      repeat (n) push_byte(8'($urandom_range(0, 255)));
      push_byte(8'h00);
      return;
    end
    broken = (kind < 35);
    if ((lim <= 64 && $urandom_range(0, 3) == 0) ||
        (lim > 64 && lim <= 300 && $urandom_range(0, 15) == 0)) begin
      target = $urandom_range(lim > 6 ? lim - 6 : 0, lim + 4);
    end else begin
      target = $urandom_range(0, lim > 20 ? 24 : lim + 4);
    end
    break_at = $urandom_range(0, target);
    sent = 0;
    while (sent < target) begin
      n = $urandom_range(1, 4);
      case (n)
        1: char_bytes[0] = 8'($urandom_range(1, CONT_LO - 1));
        2: char_bytes[0] = 8'($urandom_range(LEAD2_LO, LEAD3_LO - 1));
        3: char_bytes[0] = 8'($urandom_range(LEAD3_LO, LEAD4_LO - 1));
        default: char_bytes[0] = 8'($urandom_range(LEAD4_LO, LEAD_END - 1));
      endcase
      for (k = 1; k < 4; k++) char_bytes[k] = 8'($urandom_range(CONT_LO, LEAD2_LO - 1));
      for (k = 0; k < n; k++) begin
        if (broken && sent == break_at) begin
          push_byte(8'($urandom_range(0, 255)));
        end else begin
          push_byte(char_bytes[k]);
        end
        sent++;
      end
    end
    push_byte(8'h00);
  endtask

  task automatic random_phase(input int unsigned budget);
    int unsigned mark;
    mark = live_bytes;
    while (live_bytes - mark < budget) send_random_string();
  endtask

  // A string of plain ASCII closed by one three-byte character, then its terminator.
  task automatic long_text(input int unsigned ascii_count);
    repeat (ascii_count) push_byte(8'($urandom_range(1, CONT_LO - 1)));
    push_byte(8'($urandom_range(LEAD3_LO, LEAD4_LO - 1)));
    push_byte(8'($urandom_range(CONT_LO, LEAD2_LO - 1)));
    push_byte(8'($urandom_range(CONT_LO, LEAD2_LO - 1)));
    push_byte(8'h00);
  endtask

  // Result side: random stalls, steady stretches, and one long hold-off on request.
  initial begin : result_sink
    int unsigned rx_gap;
    rx_gap = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (rx_gap != 0) begin
        out_tready <= 1'b0;
        rx_gap--;
      end else begin
        out_tready <= 1'b1;
        if (!steady && $urandom_range(0, 2) == 0) rx_gap = pick_gap();
      end
    end
  end

  // Stimulus and final verdict.
  initial begin : stimulus
    int unsigned i;
    // Empty string, the top ASCII byte, widest legal forms (overlong included),
    // illegal leads, a bad continuation with and without the terminator.
    opening = '{8'h00,
                8'h7F, 8'h00,
                8'hC0, 8'h80, 8'hE0, 8'h80, 8'hBF, 8'hF4, 8'hBF, 8'hBF, 8'hBF, 8'h00,
                8'h80, 8'h41, 8'h00,
                8'hF5, 8'h00,
                8'hC2, 8'h41, 8'h00,
                8'hE0, 8'h80, 8'h00,
                8'hF0, 8'hC0, 8'h00,
                8'h00};
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < 28; i++) push_byte(opening[i]);

    // Fill the result buffer behind a long hold-off so the input side must stall.
    steady       = 1'b1;
    hold_request = 1'b1;
    repeat (40) push_byte(8'h00);
    steady = 1'b0;
    random_phase(FIRST_BYTES);

    // Zero limit: any byte is too long, but an illegal byte is reported first.
    set_limit(16'd0);
    push_byte(8'h41); push_byte(8'h00); push_byte(8'h00);
    push_byte(8'hE0); push_byte(8'h41); push_byte(8'h00);
    random_phase(PHASE_BYTES);

    // Limit of two: length is judged only when a character completes.
    set_limit(16'd2);
    push_byte(8'hC2); push_byte(8'h80); push_byte(8'h00);
    push_byte(8'hE0); push_byte(8'h80); push_byte(8'h80); push_byte(8'h00);
    random_phase(PHASE_BYTES);

    set_limit(16'd1);
    random_phase(PHASE_BYTES);
    set_limit(16'd5);
    random_phase(PHASE_BYTES);
    set_limit(16'd13);
    random_phase(PHASE_BYTES);
    set_limit(16'd40);
    random_phase(PHASE_BYTES);
    set_limit(16'($urandom_range(0, 16'hFFFF)));
    random_phase(PHASE_BYTES);

    // Largest limit with ordinary traffic.
    set_limit(16'hFFFF);
    random_phase(PHASE_BYTES);

    // Limit of 64: one string exactly at it and one a byte over.
    set_limit(16'd64);
    steady = 1'b1;
    long_text(32'd61);
    long_text(32'd62);
    steady = 1'b0;

    drain();
    $display("Run covered %0d bytes and %0d terminators over %0d limit settings.",
             bytes_sent, strings_sent, settings_used);
    $display("%0d verdicts were compared, %0d of them failed.", verdicts_checked, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- utf8_text_length_checker.f -----
hdl/utf8tlc_pkg.sv
hdl/utf8tlc_obuf.sv
hdl/utf8_text_length_checker.sv
hdl/utf8tlc_checker.sv
sim/utf8_verdict_checker.sv
sim/tb.sv
